// ----- design/two_line_assembly_schedule_defines.svh -----
// assertion macros used by the checker
`ifndef TWO_LINE_ASSEMBLY_SCHEDULE_DEFINES_SVH
`define TWO_LINE_ASSEMBLY_SCHEDULE_DEFINES_SVH

// consequent holds in the same cycle as the antecedent
`define TLAS_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// consequent holds in the cycle after the antecedent
`define TLAS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- design/tlas_pkg.sv -----
package tlas_pkg;

   localparam int TIME_W = 20;
   localparam int WORK_W = 12;
   localparam int INDEX_W = 6;

   localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};

   // predecessor code of a first station: each line stays on itself
   localparam logic [1:0] PRED_FIRST = 2'b10;

   localparam logic LINE_A = 1'b0;
   localparam logic LINE_B = 1'b1;

   typedef struct packed {
      logic [TIME_W-1:0] best_a;
      logic [TIME_W-1:0] best_b;
      logic [1:0]        pred;
   } tlas_step_type;

   // add with saturation at the largest time
   function automatic logic [TIME_W-1:0] sat_add(input logic [TIME_W-1:0] x,
                                                 input logic [TIME_W-1:0] y);
      logic [TIME_W:0] s;
      s = {1'b0, x} + {1'b0, y};
      return s[TIME_W] ? TIME_MAX : s[TIME_W-1:0];
   endfunction

   function automatic logic [TIME_W-1:0] widen(input logic [WORK_W-1:0] v);
      return {{(TIME_W-WORK_W){1'b0}}, v};
   endfunction

endpackage

// ----- design/tlas_step.sv -----
module tlas_step (
   input  logic                         first_station,
   input  logic [tlas_pkg::WORK_W-1:0]  work_time_a,
   input  logic [tlas_pkg::WORK_W-1:0]  work_time_b,
   input  logic [tlas_pkg::WORK_W-1:0]  move_cost_a,
   input  logic [tlas_pkg::WORK_W-1:0]  move_cost_b,
   input  logic [tlas_pkg::TIME_W-1:0]  best_a,
   input  logic [tlas_pkg::TIME_W-1:0]  best_b,
   output tlas_pkg::tlas_step_type      step
);
   import tlas_pkg::*;

   logic [TIME_W-1:0] wa, wb, ma, mb;
   logic [TIME_W-1:0] stay_a, swap_a, stay_b, swap_b;

   assign wa = widen(work_time_a);
   assign wb = widen(work_time_b);
   assign ma = widen(move_cost_a);
   assign mb = widen(move_cost_b);

   // candidate finishing times on each line
   assign stay_a = sat_add(best_a, wa);
   assign swap_a = sat_add(sat_add(best_b, mb), wa);
   assign stay_b = sat_add(best_b, wb);
   assign swap_b = sat_add(sat_add(best_a, ma), wb);

   // stay only when strictly cheaper, a tie takes the switch
   always_comb begin
      if (first_station) begin
         step.best_a = sat_add(wa, ma);
         step.best_b = sat_add(wb, mb);
         step.pred   = PRED_FIRST;
      end else begin
         if (stay_a < swap_a) begin
            step.best_a  = stay_a;
            step.pred[0] = LINE_A;
         end else begin
            step.best_a  = swap_a;
            step.pred[0] = LINE_B;
         end
         if (stay_b < swap_b) begin
            step.best_b  = stay_b;
            step.pred[1] = LINE_B;
         end else begin
            step.best_b  = swap_b;
            step.pred[1] = LINE_A;
         end
      end
   end

endmodule

// ----- design/two_line_assembly_schedule.sv -----
// two-line assembly schedule
// req channel: one transaction per station, first_station starts a route and
// carries the entry times, last_station closes it and carries the exit times.
// stations are taken one per cycle; a station that is neither first nor fits
// in the predecessor memory is taken and dropped without effect.
// rsp channel: after the last station the route comes back last station
// first, one transaction per station, route_end on station zero, each with
// the same total_time.
// the first route entry follows the last station through the final state, which
// adds the exit times, and then through the output register.
// after that one entry per cycle, set by the registered read of the
// predecessor memory that feeds the line of the next entry.
// req_ready is low from the last station until the final entry is loaded.
// a stalled rsp_ready holds the output register and pauses the traceback.
// reset clears the best times, the station count and the output valid; the
// predecessor memory is not cleared and is only read where it was written.
module two_line_assembly_schedule #(
   parameter int MAX_STATIONS = 64
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic                         req_first_station,
   input  logic                         req_last_station,
   input  logic [tlas_pkg::WORK_W-1:0]  req_work_time_a,
   input  logic [tlas_pkg::WORK_W-1:0]  req_work_time_b,
   input  logic [tlas_pkg::WORK_W-1:0]  req_move_cost_a,
   input  logic [tlas_pkg::WORK_W-1:0]  req_move_cost_b,
   input  logic [tlas_pkg::WORK_W-1:0]  req_exit_time_a,
   input  logic [tlas_pkg::WORK_W-1:0]  req_exit_time_b,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic [tlas_pkg::INDEX_W-1:0] rsp_station_index,
   output logic                         rsp_chosen_line,
   output logic [tlas_pkg::TIME_W-1:0]  rsp_total_time,
   output logic                         rsp_route_end
);
   import tlas_pkg::*;

   localparam int IDX_W = $clog2(MAX_STATIONS);
   localparam int CNT_W = $clog2(MAX_STATIONS + 1);

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_FINAL = 2'd1;
   localparam logic [1:0] ST_TRACE = 2'd2;

   logic [1:0]        state_ff, state_in;
   logic [TIME_W-1:0] best_a_ff, best_a_in, best_b_ff, best_b_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [WORK_W-1:0] exit_a_ff, exit_a_in, exit_b_ff, exit_b_in;
   logic [TIME_W-1:0] total_ff, total_in;
   logic [IDX_W-1:0]  k_ff, k_in;
   logic              line_ff, line_in;
   logic              known_ff, known_in;
   logic              rd_valid_ff;
   logic [1:0]        rd_data_ff;
   logic              out_valid_ff, out_valid_in;
   logic [INDEX_W-1:0] out_index_ff;
   logic              out_line_ff, out_end_ff;
   logic [TIME_W-1:0] out_total_ff;

   logic [1:0]        pred_mem [MAX_STATIONS];

   tlas_step_type     step;
   logic              accept, full, take, mem_we, emit, slot_free, cur_line;
   logic [IDX_W-1:0]  wr_addr;
   logic [TIME_W-1:0] exit_sum_a, exit_sum_b;

   // forward pass for one station
   tlas_step u_step (
      .first_station (req_first_station),
      .work_time_a   (req_work_time_a),
      .work_time_b   (req_work_time_b),
      .move_cost_a   (req_move_cost_a),
      .move_cost_b   (req_move_cost_b),
      .best_a        (best_a_ff),
      .best_b        (best_b_ff),
      .step          (step)
   );

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;
   assign full      = (count_ff >= CNT_W'(MAX_STATIONS));
   assign take      = accept && (req_first_station || !full);
   assign mem_we    = take;
   assign wr_addr   = req_first_station ? '0 : count_ff[IDX_W-1:0];

   // totals with exit times
   assign exit_sum_a = sat_add(best_a_ff, widen(exit_a_ff));
   assign exit_sum_b = sat_add(best_b_ff, widen(exit_b_ff));

   // traceback: line of the next entry comes straight from the read data
   assign slot_free = !out_valid_ff || rsp_ready;
   assign cur_line  = rd_valid_ff ? rd_data_ff[line_ff] : line_ff;
   assign emit      = (state_ff == ST_TRACE) && (known_ff || rd_valid_ff) && slot_free;

   always_comb begin
      state_in     = state_ff;
      best_a_in    = best_a_ff;
      best_b_in    = best_b_ff;
      count_in     = count_ff;
      exit_a_in    = exit_a_ff;
      exit_b_in    = exit_b_ff;
      total_in     = total_ff;
      k_in         = k_ff;
      line_in      = line_ff;
      known_in     = known_ff;
      out_valid_in = out_valid_ff && !rsp_ready;
      case (state_ff)
         ST_IDLE: begin
            if (take) begin
               best_a_in = step.best_a;
               best_b_in = step.best_b;
               count_in  = req_first_station ? CNT_W'(1) : count_ff + CNT_W'(1);
               exit_a_in = req_exit_time_a;
               exit_b_in = req_exit_time_b;
               if (req_last_station) begin
                  state_in = ST_FINAL;
               end
            end
         end
         ST_FINAL: begin
            // line a only when strictly cheaper
            if (exit_sum_a < exit_sum_b) begin
               total_in = exit_sum_a;
               line_in  = LINE_A;
            end else begin
               total_in = exit_sum_b;
               line_in  = LINE_B;
            end
            k_in     = IDX_W'(count_ff - CNT_W'(1));
            count_in = '0;
            known_in = 1'b1;
            state_in = ST_TRACE;
         end
         ST_TRACE: begin
            if (emit) begin
               out_valid_in = 1'b1;
               line_in      = cur_line;
               known_in     = 1'b0;
               k_in         = k_ff - IDX_W'(1);
               if (k_ff == '0) begin
                  state_in = ST_IDLE;
               end
            end else if (rd_valid_ff) begin
               line_in  = cur_line;
               known_in = 1'b1;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control and state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         best_a_ff    <= '0;
         best_b_ff    <= '0;
         count_ff     <= '0;
         known_ff     <= 1'b0;
         rd_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         best_a_ff    <= best_a_in;
         best_b_ff    <= best_b_in;
         count_ff     <= count_in;
         known_ff     <= known_in;
         rd_valid_ff  <= emit;
         out_valid_ff <= out_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      exit_a_ff <= exit_a_in;
      exit_b_ff <= exit_b_in;
      total_ff  <= total_in;
      k_ff      <= k_in;
      line_ff   <= line_in;
      if (emit) begin
         out_index_ff <= INDEX_W'(k_ff);
         out_line_ff  <= cur_line;
         out_total_ff <= total_ff;
         out_end_ff   <= (k_ff == '0);
      end
   end

   // predecessor memory, one write port and one registered read port
   always_ff @(posedge clock) begin
      if (mem_we) begin
         pred_mem[wr_addr] <= step.pred;
      end
      if (emit) begin
         rd_data_ff <= pred_mem[k_ff];
      end
   end

   assign rsp_valid         = out_valid_ff;
   assign rsp_station_index = out_index_ff;
   assign rsp_chosen_line   = out_line_ff;
   assign rsp_total_time    = out_total_ff;
   assign rsp_route_end     = out_end_ff;

endmodule

// ----- design/tlas_checker.sv -----
`include "two_line_assembly_schedule_defines.svh"

module tlas_checker (
   input logic                         clock,
   input logic                         reset,
   input logic                         req_ready,
   input logic                         rsp_valid,
   input logic                         rsp_ready,
   input logic [tlas_pkg::INDEX_W-1:0] rsp_station_index,
   input logic                         rsp_chosen_line,
   input logic [tlas_pkg::TIME_W-1:0]  rsp_total_time,
   input logic                         rsp_route_end
);
   import tlas_pkg::*;

   logic mid_route_done;
   assign mid_route_done = rsp_valid && rsp_ready && !rsp_route_end;

   // a stalled transaction holds its payload
   `TLAS_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_station_index) && $stable(rsp_chosen_line) && $stable(rsp_total_time) && $stable(rsp_route_end), "rsp payload changed while stalled")

   // the route counts down one station per entry
   `TLAS_ASSERT_NEXT(a_index_down, clock, reset, mid_route_done, !rsp_valid || (rsp_station_index == $past(rsp_station_index) - 6'd1), "route index did not step down")

   // one total for the whole route
   `TLAS_ASSERT_NEXT(a_total_same, clock, reset, mid_route_done, !rsp_valid || (rsp_total_time == $past(rsp_total_time)), "total time changed within a route")

   // no new station is taken while a route is going out
   `TLAS_ASSERT_SAME(a_no_req_mid, clock, reset, rsp_valid && !rsp_route_end, !req_ready, "input ready during traceback")

endmodule

bind two_line_assembly_schedule tlas_checker u_checker (.*);
